// File: design/int8_linear_head_argmax_assert.svh
// Assertion macros shared by the int8 linear head argmax RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef INT8_LINEAR_HEAD_ARGMAX_ASSERT_SVH
`define INT8_LINEAR_HEAD_ARGMAX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILHA_ASSERT_NOW(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("ilha assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ILHA_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("ilha assertion failed");

`endif

// File: design/ilha_pkg.sv
// Shared types and constants of the int8 linear head argmax block.
// No dependencies; all files of the block but the assertion header use it.
package ilha_pkg;

  localparam int NUM_CLASSES_DEF  = 6;
  localparam int NUM_CHANNELS_DEF = 64;
  localparam int POOLED_WIDTH_DEF = 16;

  localparam int CLS_W       = 3;
  localparam int CH_W        = 6;
  localparam int W_W         = 8;
  localparam int SUM_W       = 32;
  localparam int CNT_W       = 7;
  localparam int PRES_W      = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_POOLED = 1'b1;

  typedef struct packed {
    logic                    is_wt;
    logic                    wr_ok;
    logic                    acc;
    logic                    dir_wr;
    logic                    direct;
    logic                    last;
    logic [CLS_W-1:0]        cls;
    logic [CH_W-1:0]         chan;
    logic signed [W_W-1:0]   weight;
    logic [PRES_W-1:0]       present;
  } ctl_t;

  typedef struct packed {
    logic vld;
    logic direct;
  } snap_ctl_t;

endpackage

// File: design/ilha_ifs.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on ilha_pkg for field widths and defaults.
interface ilha_in_if #(
  parameter int POOLED_WIDTH = ilha_pkg::POOLED_WIDTH_DEF
) ();
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [ilha_pkg::CLS_W-1:0]      class_index;
  logic [ilha_pkg::CH_W-1:0]       channel_index;
  logic signed [ilha_pkg::W_W-1:0] weight_value;
  logic signed [POOLED_WIDTH-1:0]  pooled_value;
  logic                            last;

  modport source (
    output valid, operation, class_index, channel_index, weight_value, pooled_value, last,
    input  ready
  );
  modport sink (
    input  valid, operation, class_index, channel_index, weight_value, pooled_value, last,
    output ready
  );
endinterface

interface ilha_out_if ();
  logic                       valid;
  logic                       ready;
  logic [ilha_pkg::CLS_W-1:0] best_class;
  logic                       no_winner;

  modport source (output valid, best_class, no_winner, input ready);
  modport sink   (input valid, best_class, no_winner, output ready);
endinterface

// File: design/int8_linear_head_argmax.sv
// Top level of the int8 linear head argmax classifier.
// Input channel in_ch carries either a head weight write (operation 0) or one
// pooled channel value (operation 1, in channel order, last marks the end).
// Result channel out_ch carries one item per pooled item with last set:
// best_class and, in direct mode, no_winner.
// cfg_we/cfg_wdata write the direct_argmax mode bit; write it only while idle.
// The result of a last item passes in turn through the queue, the memory read,
// multiply and accumulate stages and the registered comparison tree.
// Throughput: one item per cycle while the back end is not stalled; every class
// has its own weight bank and MAC.
// Reset clears the mode bit, channel count, sums and all valid flags; weights
// are not cleared and must be written before they are used.
// When a result waits and out_ch.ready is low the back end holds; the four-entry
// queue keeps in_ch.ready high until it fills.
// Depends on ilha_pkg, ilha_ifs and the ilha_* submodules.
module int8_linear_head_argmax #(
  parameter int NUM_CLASSES  = ilha_pkg::NUM_CLASSES_DEF,
  parameter int NUM_CHANNELS = ilha_pkg::NUM_CHANNELS_DEF,
  parameter int POOLED_WIDTH = ilha_pkg::POOLED_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ilha_in_if.sink    in_ch,
  ilha_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import ilha_pkg::*;

  localparam int QW = $bits(ctl_t) + POOLED_WIDTH;

  ctl_t                           f_ctl, b_ctl;
  logic signed [POOLED_WIDTH-1:0] f_pv, b_pv;
  logic [QW-1:0]                  q_wdata, q_rdata;
  logic                           q_push, q_ready, q_valid, q_pop;
  logic                           adv;
  snap_ctl_t                      snap_ctl;
  logic [NUM_CLASSES-1:0]         snap_mask;
  logic signed [SUM_W-1:0]        snap_sum [NUM_CLASSES];

  assign q_wdata        = {f_ctl, f_pv};
  assign {b_ctl, b_pv}  = q_rdata;

  ilha_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_CHANNELS(NUM_CHANNELS),
    .POOLED_WIDTH(POOLED_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_ctl    (f_ctl),
    .q_pooled (f_pv)
  );

  ilha_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .ready(q_ready),
    .pop  (q_pop),
    .valid(q_valid),
    .rdata(q_rdata)
  );

  ilha_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_CHANNELS(NUM_CHANNELS),
    .POOLED_WIDTH(POOLED_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ctl    (b_ctl),
    .q_pooled (b_pv),
    .adv      (adv),
    .q_pop    (q_pop),
    .snap_ctl (snap_ctl),
    .snap_mask(snap_mask),
    .snap_sum (snap_sum)
  );

  ilha_argmax #(
    .NUM_CLASSES (NUM_CLASSES),
    .POOLED_WIDTH(POOLED_WIDTH)
  ) u_argmax (
    .clk      (clk),
    .rst_n    (rst_n),
    .snap_ctl (snap_ctl),
    .snap_mask(snap_mask),
    .snap_sum (snap_sum),
    .adv      (adv),
    .out_ch   (out_ch)
  );

endmodule

// File: design/ilha_front.sv
// Front end: accepts input items, holds the mode register and channel count,
// and classifies each item into a control word for the queue. Uses ilha_pkg.
module ilha_front #(
  parameter int NUM_CLASSES  = ilha_pkg::NUM_CLASSES_DEF,
  parameter int NUM_CHANNELS = ilha_pkg::NUM_CHANNELS_DEF,
  parameter int POOLED_WIDTH = ilha_pkg::POOLED_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ilha_in_if.sink                        in_ch,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           q_ready,
  output logic                           q_push,
  output ilha_pkg::ctl_t                 q_ctl,
  output logic signed [POOLED_WIDTH-1:0] q_pooled
);
  import ilha_pkg::*;

  logic             direct_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             active;
  logic [CNT_W-1:0] cnt_after;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign q_push      = accept;
  assign q_pooled    = in_ch.pooled_value;

  always_comb begin
    active    = count_r < CNT_W'(NUM_CHANNELS);
    cnt_after = active ? count_r + CNT_W'(1) : count_r;

    q_ctl.is_wt   = in_ch.operation == OP_WEIGHT;
    q_ctl.wr_ok   = ({1'b0, in_ch.class_index} < (CLS_W + 1)'(NUM_CLASSES)) &&
                    ({1'b0, in_ch.channel_index} < (CH_W + 1)'(NUM_CHANNELS));
    q_ctl.acc     = !q_ctl.is_wt && active && !direct_r;
    q_ctl.dir_wr  = !q_ctl.is_wt && active && direct_r &&
                    (count_r < CNT_W'(NUM_CLASSES));
    q_ctl.direct  = direct_r;
    q_ctl.last    = in_ch.last;
    q_ctl.cls     = in_ch.class_index;
    q_ctl.chan    = q_ctl.is_wt ? in_ch.channel_index : count_r[CH_W-1:0];
    q_ctl.weight  = in_ch.weight_value;
    q_ctl.present = (cnt_after < CNT_W'(NUM_CLASSES)) ? PRES_W'(cnt_after)
                                                       : PRES_W'(NUM_CLASSES);

    count_nxt = count_r;
    if (accept && !q_ctl.is_wt) begin
      count_nxt = in_ch.last ? '0 : cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direct_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        direct_r <= cfg_wdata;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/ilha_queue.sv
// Small register queue that decouples the front end from the back end.
// Generic payload vector; uses ilha_pkg only for the default depth.
`include "int8_linear_head_argmax_assert.svh"

module ilha_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ilha_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign ready = cnt_r != CNT_W'(DEPTH);
  assign valid = cnt_r != '0;
  assign rdata = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop && valid) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !(pop && valid)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && pop && valid) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ILHA_ASSERT_NOW(a_queue_no_overflow, push, cnt_r != CNT_W'(DEPTH))
  `ILHA_ASSERT_NEXT(a_queue_count_up, push && !pop, cnt_r == $past(cnt_r) + CNT_W'(1))
  `ILHA_ASSERT_NOW(a_queue_empty_ptrs, cnt_r == '0, rd_ptr_r == wr_ptr_r)

endmodule

// File: design/ilha_back.sv
// Back end: weight memory banks, one multiply-accumulate lane per class and
// the per-class sums. Emits a snapshot of the sums on the last item. Uses ilha_pkg.
`include "int8_linear_head_argmax_assert.svh"

module ilha_back #(
  parameter int NUM_CLASSES  = ilha_pkg::NUM_CLASSES_DEF,
  parameter int NUM_CHANNELS = ilha_pkg::NUM_CHANNELS_DEF,
  parameter int POOLED_WIDTH = ilha_pkg::POOLED_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  ilha_pkg::ctl_t                        q_ctl,
  input  logic signed [POOLED_WIDTH-1:0]        q_pooled,
  input  logic                                  adv,
  output logic                                  q_pop,
  output ilha_pkg::snap_ctl_t                   snap_ctl,
  output logic [NUM_CLASSES-1:0]                snap_mask,
  output logic signed [ilha_pkg::SUM_W-1:0]     snap_sum [NUM_CLASSES]
);
  import ilha_pkg::*;

  localparam int AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PROD_W = W_W + POOLED_WIDTH;

  logic                          pop;
  logic signed [W_W-1:0]         rd_r     [NUM_CLASSES];
  logic                          s1_vld_r;
  ctl_t                          s1_ctl_r;
  logic signed [POOLED_WIDTH-1:0] s1_pv_r;
  logic signed [PROD_W-1:0]      prod     [NUM_CLASSES];
  logic                          s2_vld_r;
  ctl_t                          s2_ctl_r;
  logic signed [SUM_W-1:0]       s2_pv_r;
  logic signed [SUM_W-1:0]       s2_prod_r [NUM_CLASSES];
  logic signed [SUM_W-1:0]       sums_r    [NUM_CLASSES];
  logic signed [SUM_W-1:0]       sum_nxt   [NUM_CLASSES];
  snap_ctl_t                     snap_ctl_r;
  logic [NUM_CLASSES-1:0]        snap_mask_r;
  logic signed [SUM_W-1:0]       snap_sum_r [NUM_CLASSES];

  assign pop       = q_valid && adv;
  assign q_pop     = pop;
  assign snap_ctl  = snap_ctl_r;
  assign snap_mask = snap_mask_r;
  assign snap_sum  = snap_sum_r;

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_bank
    logic [W_W-1:0] wt_mem_r [NUM_CHANNELS];

    always_ff @(posedge clk) begin
      if (pop && q_ctl.is_wt && q_ctl.wr_ok && (q_ctl.cls == CLS_W'(c))) begin
        wt_mem_r[q_ctl.chan[AW-1:0]] <= q_ctl.weight;
      end
      if (adv) begin
        rd_r[c] <= wt_mem_r[q_ctl.chan[AW-1:0]];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      prod[c] = rd_r[c] * s1_pv_r;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (s2_ctl_r.dir_wr && (s2_ctl_r.chan == CH_W'(c))) begin
        sum_nxt[c] = s2_pv_r;
      end else if (s2_ctl_r.acc) begin
        sum_nxt[c] = sums_r[c] + s2_prod_r[c];
      end else begin
        sum_nxt[c] = sums_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      snap_ctl_r <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        sums_r[c] <= '0;
      end
    end else if (adv) begin
      s1_vld_r       <= pop && !q_ctl.is_wt;
      s2_vld_r       <= s1_vld_r;
      snap_ctl_r.vld <= s2_vld_r && s2_ctl_r.last;
      snap_ctl_r.direct <= s2_ctl_r.direct;
      if (s2_vld_r) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          sums_r[c] <= s2_ctl_r.last ? '0 : sum_nxt[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r <= q_ctl;
      s1_pv_r  <= q_pooled;
      s2_ctl_r <= s1_ctl_r;
      s2_pv_r  <= SUM_W'(s1_pv_r);
      for (int c = 0; c < NUM_CLASSES; c++) begin
        s2_prod_r[c]   <= SUM_W'(prod[c]);
        snap_sum_r[c]  <= sum_nxt[c];
        snap_mask_r[c] <= !s2_ctl_r.direct || (PRES_W'(c) < s2_ctl_r.present);
      end
    end
  end

  `ILHA_ASSERT_NEXT(a_sums_clear_after_last, adv && s2_vld_r && s2_ctl_r.last, sums_r[0] == '0)
  `ILHA_ASSERT_NOW(a_one_mode_per_item, s2_vld_r && s2_ctl_r.dir_wr, !s2_ctl_r.acc)
  `ILHA_ASSERT_NEXT(a_stall_holds_sums, !adv, sums_r[0] == $past(sums_r[0]))

endmodule

// File: design/ilha_argmax.sv
// Pipelined comparison tree that picks the lowest-index largest sum, plus the
// output register of the result channel. Uses ilha_pkg and ilha_out_if.
`include "int8_linear_head_argmax_assert.svh"

module ilha_argmax #(
  parameter int NUM_CLASSES  = ilha_pkg::NUM_CLASSES_DEF,
  parameter int POOLED_WIDTH = ilha_pkg::POOLED_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ilha_pkg::snap_ctl_t               snap_ctl,
  input  logic [NUM_CLASSES-1:0]            snap_mask,
  input  logic signed [ilha_pkg::SUM_W-1:0] snap_sum [NUM_CLASSES],
  output logic                              adv,
  ilha_out_if.source                        out_ch
);
  import ilha_pkg::*;

  localparam int LVL    = $clog2(NUM_CLASSES);
  localparam int LEAVES = 1 << LVL;
  localparam logic signed [SUM_W-1:0] MIN_SCORE = -(SUM_W'(1) << (POOLED_WIDTH - 1));

  typedef struct packed {
    logic                    valid;
    logic [CLS_W-1:0]        idx;
    logic signed [SUM_W-1:0] val;
  } node_t;

  function automatic node_t pick(node_t a, node_t b);
    if (b.valid && (!a.valid || ($signed(b.val) > $signed(a.val)))) begin
      return b;
    end
    return a;
  endfunction

  node_t            leaf      [LEAVES];
  node_t            lvl_r     [LVL][LEAVES];
  snap_ctl_t        lvl_ctl_r [LVL];
  node_t            fin;
  logic             none;
  logic             out_vld_r;
  logic [CLS_W-1:0] best_r;
  logic             none_r;

  for (genvar n = 0; n < LEAVES; n++) begin : g_leaf
    if (n < NUM_CLASSES) begin : g_used
      assign leaf[n] = '{valid: snap_mask[n], idx: CLS_W'(n), val: snap_sum[n]};
    end else begin : g_pad
      assign leaf[n] = '0;
    end
  end

  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    for (genvar n = 0; n < LEAVES; n++) begin : g_node
      if (n >= (LEAVES >> (l + 1))) begin : g_idle
        always_ff @(posedge clk) begin
          lvl_r[l][n] <= '0;
        end
      end else if (l == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv) begin
            lvl_r[l][n] <= pick(leaf[2*n], leaf[2*n+1]);
          end
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          if (adv) begin
            lvl_r[l][n] <= pick(lvl_r[l-1][2*n], lvl_r[l-1][2*n+1]);
          end
        end
      end
    end

    if (l == 0) begin : g_ctl_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          lvl_ctl_r[l] <= '0;
        end else if (adv) begin
          lvl_ctl_r[l] <= snap_ctl;
        end
      end
    end else begin : g_ctl_inner
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          lvl_ctl_r[l] <= '0;
        end else if (adv) begin
          lvl_ctl_r[l] <= lvl_ctl_r[l-1];
        end
      end
    end
  end

  assign fin  = lvl_r[LVL-1][0];
  assign none = lvl_ctl_r[LVL-1].direct &&
                (!fin.valid || ($signed(fin.val) <= MIN_SCORE));
  assign adv  = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= lvl_ctl_r[LVL-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      best_r <= none ? '0 : fin.idx;
      none_r <= none;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.best_class = best_r;
  assign out_ch.no_winner  = none_r;

  `ILHA_ASSERT_NOW(a_no_winner_is_class0, out_vld_r && none_r, best_r == '0)
  `ILHA_ASSERT_NOW(a_weighted_has_winner, lvl_ctl_r[LVL-1].vld && !lvl_ctl_r[LVL-1].direct, fin.valid)
  `ILHA_ASSERT_NOW(a_winner_in_range, out_vld_r, best_r < CLS_W'(NUM_CLASSES))

endmodule

// File: sim/tb_int8_linear_head_argmax.sv
// Self-checking testbench for the int8 linear head argmax classifier.
// Drives weight writes and pooled vectors in both scoring modes, predicts each winner, checks it.
// Depends on ilha_pkg, the ilha_in_if/ilha_out_if interfaces and the int8_linear_head_argmax RTL.
module tb_int8_linear_head_argmax;
  timeunit 1ns;
  timeprecision 1ps;
  import ilha_pkg::*;

  localparam int NCLS = NUM_CLASSES_DEF;
  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int PW = POOLED_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [PW-1:0] PMAX = ~PMIN;

  typedef struct {
    logic                  op;
    logic [CLS_W-1:0]      cls;
    logic [CH_W-1:0]       ch;
    logic signed [W_W-1:0] wt;
    logic signed [PW-1:0]  pv;
    logic                  last;
    bit                    hold;
  } head_item_t;

  typedef struct {
    logic [CLS_W-1:0] best;
    logic             none;
  } winner_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  ilha_in_if  in_ch ();
  ilha_out_if out_ch ();

  int8_linear_head_argmax DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  head_item_t stim_q[$];
  winner_t    winner_q[$];
  head_item_t cur;
  head_item_t seen;
  winner_t    got;
  winner_t    want;
  int         idle_pct;
  int         stall_pct;
  bit         in_took;
  int         mismatches;
  int         quiet_cycles;

  logic signed [W_W-1:0]   weight_mem [NCLS][NCH];
  logic signed [SUM_W-1:0] class_acc [NCLS];
  int                      chan_pos;
  bit                      mode_direct;

  bit col_written [NCLS][NCH];
  int gen_pos;
  int gen_items;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void predict_winner(input head_item_t it);
    winner_t                 res;
    logic signed [SUM_W-1:0] top;
    int                      present;
    if (it.op == OP_WEIGHT) begin
      if (it.cls < NCLS && it.ch < NCH) weight_mem[it.cls][it.ch] = it.wt;
      return;
    end
    if (chan_pos < NCH) begin
      if (mode_direct) begin
        if (chan_pos < NCLS) class_acc[chan_pos] = SUM_W'(it.pv);
      end else begin
        for (int c = 0; c < NCLS; c++)
          class_acc[c] = class_acc[c] + weight_mem[c][chan_pos] * it.pv;
      end
      chan_pos++;
    end
    if (!it.last) return;
    res.best = '0;
    res.none = 1'b0;
    if (mode_direct) begin
      top = SUM_W'(PMIN);
      present = (chan_pos < NCLS) ? chan_pos : NCLS;
      res.none = 1'b1;
      for (int c = 0; c < present; c++) begin
        if (class_acc[c] > top) begin
          top = class_acc[c];
          res.best = CLS_W'(c);
          res.none = 1'b0;
        end
      end
    end else begin
      top = class_acc[0];
      for (int c = 1; c < NCLS; c++) begin
        if (class_acc[c] > top) begin
          top = class_acc[c];
          res.best = CLS_W'(c);
        end
      end
    end
    winner_q.push_back(res);
    foreach (class_acc[c]) class_acc[c] = '0;
    chan_pos = 0;
  endfunction

  function automatic logic signed [W_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 8'sh80;
      1: return 8'sh7f;
      default: return W_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [PW-1:0] pick_pooled(input int style,
                                                       input logic signed [PW-1:0] fixed);
    case (style)
      1: return PW'($urandom_range(0, 6) - 3);
      2: return $urandom_range(0, 1) ? PMAX : PMIN;
      3: return PMIN;
      4: return fixed;
      default: return PW'($urandom);
    endcase
  endfunction

  function automatic void push_weight(input int cls, input int ch,
                                      input logic signed [W_W-1:0] w, input logic last);
    head_item_t it;
    it.op = OP_WEIGHT;
    it.cls = CLS_W'(cls);
    it.ch = CH_W'(ch);
    it.wt = w;
    it.pv = PW'($urandom);
    it.last = last;
    it.hold = 1'b0;
    if (cls < NCLS) col_written[cls][ch] = 1'b1;
    stim_q.push_back(it);
    gen_items++;
  endfunction

  // A column must be fully written before any pooled item at that position is sent.
  function automatic void push_pooled(input logic signed [PW-1:0] pv, input logic last,
                                      input bit hold);
    head_item_t it;
    if (gen_pos < NCH) begin
      for (int c = 0; c < NCLS; c++)
        if (!col_written[c][gen_pos]) push_weight(c, gen_pos, pick_weight(), 1'($urandom));
    end
    it.op = OP_POOLED;
    it.cls = CLS_W'($urandom);
    it.ch = CH_W'($urandom);
    it.wt = W_W'($urandom);
    it.pv = pv;
    it.last = last;
    it.hold = hold;
    stim_q.push_back(it);
    gen_items++;
    if (last) gen_pos = 0;
    else if (gen_pos < NCH) gen_pos++;
  endfunction

  function automatic void push_vector(input bit closed, input bit hold);
    int                   r;
    int                   len;
    int                   style;
    logic signed [PW-1:0] fixed;
    r = $urandom_range(0, 99);
    if (r < 65) len = $urandom_range(1, 8);
    else if (r < 85) len = $urandom_range(9, 40);
    else if (r < 93) len = NCH;
    else len = $urandom_range(NCH + 1, NCH + 6);
    style = $urandom_range(0, 5);
    fixed = PW'($urandom);
    for (int i = 0; i < len; i++)
      push_pooled(pick_pooled(style, fixed), closed && i == len - 1, hold && i == 0);
  endfunction

  task automatic wait_drained();
    while (stim_q.size() != 0 || in_ch.valid || winner_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic direct);
    wait_drained();
    @(negedge clk);
    cfg_wdata <= direct;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic direct, input int idle, input int stall,
                           input int budget, input bit leave_open);
    int goal;
    bit first;
    write_mode(direct);
    idle_pct = idle;
    stall_pct = stall;
    goal = gen_items + budget;
    first = 1'b1;
    while (gen_items < goal) begin
      if ($urandom_range(0, 99) < 20) begin
        repeat ($urandom_range(1, 6))
          push_weight($urandom_range(0, 7), $urandom_range(0, NCH - 1), pick_weight(),
                      1'($urandom));
      end else begin
        push_vector(1'b1, first || $urandom_range(0, 29) == 0);
        first = 1'b0;
      end
    end
    if (leave_open) push_vector(1'b0, 1'b0);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (stim_q.size() != 0 && !(stim_q[0].hold && winner_q.size() != 0) &&
          $urandom_range(0, 99) >= idle_pct) begin
        cur = stim_q.pop_front();
        in_ch.operation <= cur.op;
        in_ch.class_index <= cur.cls;
        in_ch.channel_index <= cur.ch;
        in_ch.weight_value <= cur.wt;
        in_ch.pooled_value <= cur.pv;
        in_ch.last <= cur.last;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_we) mode_direct = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        seen.op = in_ch.operation;
        seen.cls = in_ch.class_index;
        seen.ch = in_ch.channel_index;
        seen.wt = in_ch.weight_value;
        seen.pv = in_ch.pooled_value;
        seen.last = in_ch.last;
        seen.hold = 1'b0;
        predict_winner(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.best = out_ch.best_class;
        got.none = out_ch.no_winner;
        if (winner_q.size() == 0) begin
          $display("%0t: unexpected result, best_class %0d no_winner %0b",
                   $time, got.best, got.none);
          mismatches++;
        end else begin
          want = winner_q.pop_front();
          if (got.best !== want.best) begin
            $display("%0t: best_class expected %0d, actual %0d", $time, want.best, got.best);
            mismatches++;
          end
          if (got.none !== want.none) begin
            $display("%0t: no_winner expected %0b, actual %0b", $time, want.none, got.none);
            mismatches++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL int8_linear_head_argmax");
        $finish;
      end
    end
  end

  initial begin
    logic signed [PW-1:0] scores [8];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WEIGHT;
    in_ch.class_index = '0;
    in_ch.channel_index = '0;
    in_ch.weight_value = '0;
    in_ch.pooled_value = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    quiet_cycles = 0;
    chan_pos = 0;
    mode_direct = 1'b0;
    gen_pos = 0;
    gen_items = 0;
    foreach (class_acc[c]) class_acc[c] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Weighted mode: ignored rows, extreme weights and activations, ties and all-equal sums.
    write_mode(1'b0);
    push_weight(6, 0, 8'sh7f, 1'b0);
    push_weight(7, 63, 8'sh80, 1'b1);
    push_weight(0, 0, 8'sh80, 1'b0);
    push_weight(1, 0, 8'sh7f, 1'b0);
    push_weight(2, 0, 8'sh00, 1'b0);
    push_weight(3, 0, 8'sh01, 1'b0);
    push_weight(4, 0, 8'shff, 1'b0);
    push_weight(5, 0, 8'sh7f, 1'b0);
    push_weight(5, 63, 8'sh7f, 1'b1);
    push_pooled(PMAX, 1'b1, 1'b0);
    push_pooled(PMIN, 1'b1, 1'b0);
    push_pooled('0, 1'b1, 1'b0);
    push_pooled(16'sd100, 1'b0, 1'b0);
    push_pooled(-16'sd5, 1'b1, 1'b0);

    // Direct mode: no winner, ties, ignored later values, short vectors.
    write_mode(1'b1);
    repeat (2) push_pooled(PMIN, 1'b0, 1'b0);
    push_pooled(PMIN, 1'b1, 1'b0);
    scores = '{3, 7, 7, -1, 2, 7, PMAX, PMAX};
    foreach (scores[i]) push_pooled(scores[i], i == 7, 1'b0);
    repeat (5) push_pooled(PMIN, 1'b0, 1'b0);
    push_pooled(PMIN + PW'(1), 1'b1, 1'b0);
    push_pooled(PMAX, 1'b1, 1'b0);

    run_phase(1'b0, 0, 0, 70, 1'b1);
    run_phase(1'b1, 55, 0, 70, 1'b1);
    run_phase(1'b0, 0, 55, 70, 1'b0);
    run_phase(1'b1, 6, 6, 70, 1'b1);
    run_phase(1'b0, 0, 0, 70, 1'b0);
    run_phase(1'b1, 55, 0, 70, 1'b0);

    wait_drained();
    if (mismatches == 0 && winner_q.size() == 0) begin
      $display("PASS int8_linear_head_argmax");
    end else begin
      $display("FAIL int8_linear_head_argmax");
    end
    $finish;
  end

endmodule
